>>> rtl/spdl_pkg.sv
// Package with types, sizes and codes for the sprite priority display list.
package spdl_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RUN_W = 6;
    localparam int PRIO_W = 7;
    localparam int SUM_W = ((CNT_W > RUN_W) ? CNT_W : RUN_W) + 1;
    localparam logic [PRIO_W-1:0] PRIO_CEILING = PRIO_W'(100);

    typedef enum logic [1:0] {
        FN_PUT    = 2'd0,
        FN_DELETE = 2'd1,
        FN_DRAW   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RUN_LONG  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RESULT,
        S_DS_RD,
        S_DS_EV,
        S_SH_RD,
        S_SH_EV,
        S_DEL_FIN,
        S_SO_START,
        S_SO_RD,
        S_SO_EV,
        S_SO_SW1,
        S_SO_SW2,
        S_DR_START,
        S_DR_RD,
        S_DR_EV
    } state_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [PRIO_W-1:0]  prio;
        logic               cam;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]         pad;
        logic [RUN_W-1:0]   run_length;
        logic signed [15:0] camera_y;
        logic signed [15:0] camera_x;
        logic               camera_dependent;
        logic [PRIO_W-1:0]  priority_req;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic [15:0]        sprite_tag;
    } in_data_t;

    typedef struct packed {
        logic [2:0]         pad;
        status_t            status;
        logic signed [16:0] screen_y;
        logic signed [16:0] screen_x;
        logic [15:0]        out_tag;
    } out_data_t;

endpackage

>>> rtl/spdl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rdata_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rdata_reg;
endmodule

>>> rtl/sprite_priority_display_list.sv
// Top level of the sprite priority display list.
//
// The block holds a table of up to TABLE_DEPTH sprites in a RAM with one write
// and one registered read port, and handles one input transfer at a time; it
// is not ready until that item is fully worked off. A delete searches the
// entries up to the first match, then moves each later entry down. A draw
// with an unchanged table emits its entries in table order; after a change it
// first sorts, with a selection sort that reads every remaining entry through
// the single read port at each position. Results leave through an output
// register, so a new item may be accepted while the last result still waits
// to be taken. The table needs no clearing after reset.
module sprite_priority_display_list (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // sprite_tag, pos_x, pos_y, priority_req, camera_dependent, camera_x,
    // camera_y, run_length, zero fill
    input  spdl_pkg::in_data_t  s_tdata,
    // func
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_tag, screen_x, screen_y, status, zero fill
    output spdl_pkg::out_data_t m_tdata,
    output logic                m_tlast
);
    import spdl_pkg::*;

    state_t state_reg, state_next;
    func_t func_reg, func_next;
    in_data_t in_reg, in_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic sorted_reg, sorted_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] aux_reg, aux_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    entry_t first_ent_reg, first_ent_next;
    entry_t best_ent_reg, best_ent_next;
    status_t status_reg, status_next;
    logic m_valid_reg, m_valid_next;
    out_data_t m_data_reg, m_data_next;
    logic m_last_reg, m_last_next;

    logic ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t ram_wr_data;
    entry_t ram_rd_data;
    logic [ENTRY_W-1:0] ram_rd_bits;

    logic in_fire;
    logic slot_free;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] aux_inc;
    logic idx_last;
    logic aux_last;
    logic hit;
    logic [SUM_W-1:0] run_end;
    logic too_long;
    logic no_move;
    logic table_full;
    logic signed [16:0] scr_x;
    logic signed [16:0] scr_y;

    spdl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_bits)
    );

    assign ram_rd_data = entry_t'(ram_rd_bits);

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign aux_inc = CNT_W'(aux_reg) + CNT_W'(1);
    assign idx_last = (idx_inc >= count_reg);
    assign aux_last = (aux_inc >= count_reg);
    assign hit = (ram_rd_data.tag == in_reg.sprite_tag);
    assign run_end = SUM_W'(idx_reg) + SUM_W'(in_reg.run_length);
    assign too_long = (run_end > SUM_W'(count_reg));
    assign no_move = (run_end == SUM_W'(count_reg));
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    assign scr_x = {ram_rd_data.x[15], ram_rd_data.x}
                 - (ram_rd_data.cam ? {in_reg.camera_x[15], in_reg.camera_x} : 17'sd0);
    assign scr_y = {ram_rd_data.y[15], ram_rd_data.y}
                 - (ram_rd_data.cam ? {in_reg.camera_y[15], in_reg.camera_y} : 17'sd0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (func_reg)
                    FN_PUT: state_next = S_RESULT;
                    FN_DELETE: begin
                        state_next = (count_reg == '0) ? S_RESULT : S_DS_RD;
                    end
                    FN_DRAW: begin
                        state_next = (sorted_reg || count_reg == '0) ? S_DR_START
                                                                     : S_SO_START;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RESULT: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DS_RD: state_next = S_DS_EV;
            S_DS_EV: begin
                if (hit) begin
                    if (too_long || in_reg.run_length == '0) begin
                        state_next = S_RESULT;
                    end else if (no_move) begin
                        state_next = S_DEL_FIN;
                    end else begin
                        state_next = S_SH_RD;
                    end
                end else if (idx_last) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_DS_RD;
                end
            end
            S_SH_RD: state_next = S_SH_EV;
            S_SH_EV: state_next = idx_last ? S_DEL_FIN : S_SH_RD;
            S_DEL_FIN: state_next = S_RESULT;
            S_SO_START: state_next = S_SO_RD;
            S_SO_RD: state_next = S_SO_EV;
            S_SO_EV: state_next = idx_last ? S_SO_SW1 : S_SO_RD;
            S_SO_SW1: begin
                if (pick_reg != aux_reg) begin
                    state_next = S_SO_SW2;
                end else begin
                    state_next = aux_last ? S_DR_START : S_SO_START;
                end
            end
            S_SO_SW2: state_next = aux_last ? S_DR_START : S_SO_START;
            S_DR_START: state_next = (count_reg == '0) ? S_RESULT : S_DR_RD;
            S_DR_RD: state_next = S_DR_EV;
            S_DR_EV: begin
                if (slot_free) begin
                    state_next = idx_last ? S_IDLE : S_DR_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        func_next = func_reg;
        in_next = in_reg;
        count_next = count_reg;
        sorted_next = sorted_reg;
        idx_next = idx_reg;
        aux_next = aux_reg;
        pick_next = pick_reg;
        best_prio_next = best_prio_reg;
        first_ent_next = first_ent_reg;
        best_ent_next = best_ent_reg;
        status_next = status_reg;
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_wr_en = 1'b0;
        ram_wr_addr = aux_reg;
        ram_wr_data = ram_rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    func_next = func_t'(s_tuser);
                    in_next = s_tdata;
                end
            end
            S_DECODE: begin
                unique case (func_reg)
                    FN_PUT: begin
                        if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_wr_en = 1'b1;
                            ram_wr_addr = IDX_W'(count_reg);
                            ram_wr_data = '{tag:  in_reg.sprite_tag,
                                            x:    in_reg.pos_x,
                                            y:    in_reg.pos_y,
                                            prio: in_reg.priority_req,
                                            cam:  in_reg.camera_dependent};
                            count_next = count_reg + CNT_W'(1);
                            sorted_next = 1'b0;
                            status_next = ST_OK;
                        end
                    end
                    FN_DELETE: begin
                        status_next = ST_EMPTY;
                        idx_next = '0;
                    end
                    FN_DRAW: begin
                        if (count_reg == '0) begin
                            sorted_next = 1'b1;
                        end
                        aux_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_RESULT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = '{pad: '0, status: status_reg, screen_y: '0,
                                    screen_x: '0, out_tag: '0};
                    m_last_next = 1'b1;
                end
            end
            S_DS_EV: begin
                if (hit) begin
                    if (too_long) begin
                        status_next = ST_RUN_LONG;
                    end else begin
                        status_next = ST_OK;
                        aux_next = idx_reg;
                        idx_next = IDX_W'(run_end);
                    end
                end else if (idx_last) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_SH_EV: begin
                ram_wr_en = 1'b1;
                ram_wr_addr = aux_reg;
                ram_wr_data = ram_rd_data;
                aux_next = IDX_W'(aux_inc);
                if (!idx_last) begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_DEL_FIN: begin
                count_next = count_reg - CNT_W'(in_reg.run_length);
                sorted_next = 1'b0;
                status_next = ST_OK;
            end
            S_SO_START: begin
                idx_next = aux_reg;
                pick_next = aux_reg;
                best_prio_next = PRIO_CEILING;
            end
            S_SO_EV: begin
                if (idx_reg == aux_reg) begin
                    first_ent_next = ram_rd_data;
                end
                if (ram_rd_data.prio < best_prio_reg) begin
                    best_prio_next = ram_rd_data.prio;
                    pick_next = idx_reg;
                    best_ent_next = ram_rd_data;
                end
                if (!idx_last) begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_SO_SW1: begin
                if (pick_reg != aux_reg) begin
                    ram_wr_en = 1'b1;
                    ram_wr_addr = pick_reg;
                    ram_wr_data = first_ent_reg;
                end else if (aux_last) begin
                    sorted_next = 1'b1;
                end else begin
                    aux_next = IDX_W'(aux_inc);
                end
            end
            S_SO_SW2: begin
                ram_wr_en = 1'b1;
                ram_wr_addr = aux_reg;
                ram_wr_data = best_ent_reg;
                if (aux_last) begin
                    sorted_next = 1'b1;
                end else begin
                    aux_next = IDX_W'(aux_inc);
                end
            end
            S_DR_START: begin
                status_next = ST_EMPTY;
                idx_next = '0;
            end
            S_DR_EV: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = '{pad: '0, status: ST_OK, screen_y: scr_y,
                                    screen_x: scr_x, out_tag: ram_rd_data.tag};
                    m_last_next = idx_last;
                    if (!idx_last) begin
                        idx_next = IDX_W'(idx_inc);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sorted_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sorted_reg <= sorted_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg <= func_next;
        in_reg <= in_next;
        idx_reg <= idx_next;
        aux_reg <= aux_next;
        pick_reg <= pick_next;
        best_prio_reg <= best_prio_next;
        first_ent_reg <= first_ent_next;
        best_ent_reg <= best_ent_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end
endmodule

>>> sim/sprite_priority_display_list_tb.sv
// Self-checking testbench for the sprite priority display list.
module sprite_priority_display_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spdl_pkg::*;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [16:0] sx;
        logic signed [16:0] sy;
        status_t            st;
        logic               last;
    } frame_res_t;

    typedef struct packed {
        logic [1:0] fn;
        in_data_t   d;
        logic       typed;
        status_t    st;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    in_data_t    s_tdata  = '0;
    logic [1:0]  s_tuser  = FN_PUT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    out_data_t   m_tdata;
    logic        m_tlast;

    entry_t      sp_table [TABLE_DEPTH];
    int          sp_count;
    bit          sp_sorted;

    frame_res_t  step_q [$];
    frame_res_t  pending_out_q [$];
    stim_row_t   plan_q [$];
    frame_res_t  want;
    int          fail_count = 0;

    int          tx_left = 0;
    bit          tx_calm = 0;
    int          rx_left = 0;
    bit          rx_calm = 0;

    sprite_priority_display_list u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(4, 24);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic in_data_t mk_data(input logic [15:0] tag, input logic [15:0] x,
                                         input logic [15:0] y, input logic [6:0] prio,
                                         input logic cam, input logic [15:0] cx,
                                         input logic [15:0] cy, input logic [5:0] run);
        in_data_t d;
        d = '0;
        d.sprite_tag       = tag;
        d.pos_x            = x;
        d.pos_y            = y;
        d.priority_req     = prio;
        d.camera_dependent = cam;
        d.camera_x         = cx;
        d.camera_y         = cy;
        d.run_length       = run;
        return d;
    endfunction

    function automatic int first_tag_index(input logic [15:0] tag);
        int i;
        for (i = 0; i < sp_count; i++) begin
            if (sp_table[i].tag == tag) begin
                return i;
            end
        end
        return sp_count;
    endfunction

    function automatic frame_res_t status_only(input status_t st);
        frame_res_t r;
        r = '0;
        r.st   = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] fn, input logic [15:0] tag, input logic [15:0] x,
                           input logic [15:0] y, input logic [6:0] prio, input logic cam,
                           input logic [15:0] cx, input logic [15:0] cy, input logic [5:0] run,
                           input logic typed, input status_t st);
        stim_row_t row;
        row.fn    = fn;
        row.d     = mk_data(tag, x, y, prio, cam, cx, cy, run);
        row.typed = typed;
        row.st    = st;
        plan_q.push_back(row);
    endtask

    task automatic update_display_list(input logic [1:0] fn, input in_data_t d);
        int         i;
        int         j;
        int         f;
        int         run;
        int         best;
        int         pick;
        entry_t     t;
        frame_res_t r;
        case (fn)
            FN_PUT: begin
                if (sp_count >= TABLE_DEPTH) begin
                    step_q.push_back(status_only(ST_FULL));
                end else begin
                    sp_table[sp_count] = {d.sprite_tag, d.pos_x, d.pos_y, d.priority_req,
                                          d.camera_dependent};
                    sp_count++;
                    sp_sorted = 0;
                    step_q.push_back(status_only(ST_OK));
                end
            end
            FN_DELETE: begin
                run = int'(d.run_length);
                f = first_tag_index(d.sprite_tag);
                if (sp_count == 0) begin
                    step_q.push_back(status_only(ST_EMPTY));
                end else if (f >= sp_count) begin
                    step_q.push_back(status_only(ST_NOT_FOUND));
                end else if (f + run > sp_count) begin
                    step_q.push_back(status_only(ST_RUN_LONG));
                end else begin
                    if (run > 0) begin
                        for (i = f; i + run < sp_count; i++) begin
                            sp_table[i] = sp_table[i + run];
                        end
                        sp_count -= run;
                        sp_sorted = 0;
                    end
                    step_q.push_back(status_only(ST_OK));
                end
            end
            FN_DRAW: begin
                if (!sp_sorted) begin
                    // Selection sort that only picks priorities below the ceiling.
                    for (i = 0; i < sp_count; i++) begin
                        best = int'(PRIO_CEILING);
                        pick = i;
                        for (j = i; j < sp_count; j++) begin
                            if (sp_table[j].prio < best) begin
                                best = int'(sp_table[j].prio);
                                pick = j;
                            end
                        end
                        if (pick != i) begin
                            t = sp_table[i];
                            sp_table[i] = sp_table[pick];
                            sp_table[pick] = t;
                        end
                    end
                    sp_sorted = 1;
                end
                if (sp_count == 0) begin
                    step_q.push_back(status_only(ST_EMPTY));
                end else begin
                    for (i = 0; i < sp_count; i++) begin
                        r.tag = sp_table[i].tag;
                        r.sx  = 17'(sp_table[i].x);
                        r.sy  = 17'(sp_table[i].y);
                        if (sp_table[i].cam) begin
                            r.sx = r.sx - d.camera_x;
                            r.sy = r.sy - d.camera_y;
                        end
                        r.st   = ST_OK;
                        r.last = (i + 1 == sp_count);
                        step_q.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] fn, input in_data_t d, input logic typed,
                             input status_t st);
        int gap;
        int k;
        gap = pick_gap(tx_left, tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        step_q.delete();
        update_display_list(fn, d);
        if (typed) begin
            pending_out_q.push_back(status_only(st));
        end else begin
            for (k = 0; k < step_q.size(); k++) begin
                pending_out_q.push_back(step_q[k]);
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_out_q.size() != 0);
    endtask

    initial begin
        int gap;
        forever begin
            gap = pick_gap(rx_left, rx_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out_q.size() == 0) begin
                $error("result transfer with no result pending: tag %h status %0d",
                       m_tdata.out_tag, m_tdata.status);
                fail_count++;
            end else begin
                want = pending_out_q.pop_front();
                if (m_tdata.out_tag !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, m_tdata.out_tag);
                    fail_count++;
                end
                if (m_tdata.screen_x !== want.sx) begin
                    $error("screen_x: expected %0d, got %0d", want.sx, m_tdata.screen_x);
                    fail_count++;
                end
                if (m_tdata.screen_y !== want.sy) begin
                    $error("screen_y: expected %0d, got %0d", want.sy, m_tdata.screen_y);
                    fail_count++;
                end
                if (m_tdata.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_tdata.status);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int        n_sent;
        int        op;
        int        f;
        int        room;
        int        r;
        int        k;
        bit        filled;
        in_data_t  d;
        stim_row_t row;

        sp_count  = 0;
        sp_sorted = 1;
        n_sent    = 0;
        filled    = 0;

        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_EMPTY);
        add_row(FN_DELETE, 16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd1,
                1'b1, ST_EMPTY);
        add_row(2'd3,      16'hA5A5, 16'h1234, 16'h4321, 7'd9,   1'b1, 16'h0F0F, 16'hF0F0, 6'd5,
                1'b0, ST_OK);
        add_row(FN_PUT,    16'hFFFF, 16'h7FFF, 16'h8000, 7'd0,   1'b1, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_PUT,    16'h0000, 16'h8000, 16'h7FFF, 7'd99,  1'b1, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_PUT,    16'h1234, 16'h0000, 16'h0000, 7'd127, 1'b0, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_PUT,    16'h0005, 16'hFFFF, 16'h0001, 7'd50,  1'b0, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_PUT,    16'h0005, 16'h0064, 16'hFF9C, 7'd100, 1'b1, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h7FFF, 16'h8000, 6'd0,
                1'b0, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h8000, 16'h7FFF, 6'd0,
                1'b0, ST_OK);
        add_row(FN_DELETE, 16'hBEEF, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd1,
                1'b1, ST_NOT_FOUND);
        add_row(FN_DELETE, 16'h0005, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd63,
                1'b1, ST_RUN_LONG);
        add_row(FN_DELETE, 16'h0005, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd0,
                1'b0, ST_OK);
        add_row(FN_DELETE, 16'hFFFF, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd1,
                1'b1, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0001, 16'hFFFF, 6'd0,
                1'b0, ST_OK);
        add_row(FN_PUT,    16'h0007, 16'h0001, 16'h0001, 7'd1,   1'b1, 16'h0000, 16'h0000, 6'd0,
                1'b1, ST_OK);
        add_row(FN_DELETE, 16'h0005, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd2,
                1'b0, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h5555, 16'hAAAA, 6'd0,
                1'b0, ST_OK);
        add_row(FN_DELETE, 16'h1234, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'h0000, 16'h0000, 6'd1,
                1'b0, ST_OK);
        add_row(2'd3,      16'h5A5A, 16'hEDCB, 16'hBCDE, 7'd118, 1'b0, 16'hF0F0, 16'h0F0F, 6'd58,
                1'b0, ST_OK);
        add_row(FN_DRAW,   16'h0000, 16'h0000, 16'h0000, 7'd0,   1'b0, 16'hAAAA, 16'h5555, 6'd0,
                1'b0, ST_OK);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < plan_q.size(); k++) begin
            row = plan_q[k];
            send_item(row.fn, row.d, row.typed, row.st);
        end

        drain_results();

        while (n_sent < 80) begin
            op = $urandom_range(0, 99);
            if ((!filled && n_sent >= 30) || (op < 3)) begin
                // Fill the table, then overflow it once or twice.
                filled = 1;
                while (sp_count < TABLE_DEPTH) begin
                    d = mk_data(16'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 7'($urandom_range(0, 99)),
                                1'($urandom_range(0, 1)), 16'h0000, 16'h0000, 6'd0);
                    send_item(FN_PUT, d, 1'b0, ST_OK);
                    n_sent++;
                end
                repeat ($urandom_range(1, 2)) begin
                    d = mk_data(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                                1'($urandom_range(0, 1)), 16'h0000, 16'h0000, 6'd0);
                    send_item(FN_PUT, d, 1'b0, ST_OK);
                    n_sent++;
                end
            end else if (op < 40) begin
                d = mk_data(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            7'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                                           : $urandom_range(0, 99)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)));
                send_item(FN_PUT, d, 1'b0, ST_OK);
                n_sent++;
            end else if (op < 65 && sp_count > 0) begin
                f = first_tag_index(sp_table[$urandom_range(0, sp_count - 1)].tag);
                room = sp_count - f;
                r = $urandom_range(0, 9);
                d = mk_data(sp_table[f].tag, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)),
                            6'((r < 6) ? $urandom_range(1, (room < 4) ? room : 4) :
                               (r < 8) ? $urandom_range(1, room) : $urandom_range(0, 63)));
                send_item(FN_DELETE, d, 1'b0, ST_OK);
                n_sent++;
            end else if (op < 73) begin
                d = mk_data(16'($urandom_range(0, 65535)), 16'h0000, 16'h0000, 7'd0, 1'b0,
                            16'h0000, 16'h0000, 6'($urandom_range(0, 63)));
                send_item(FN_DELETE, d, 1'b0, ST_OK);
                n_sent++;
            end else if (op < 95) begin
                d = mk_data(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)));
                send_item(FN_DRAW, d, 1'b0, ST_OK);
                n_sent++;
            end else begin
                d = mk_data(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)));
                send_item(2'd3, d, 1'b0, ST_OK);
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (64) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/spdl_pkg.sv
rtl/spdl_ram.sv
rtl/sprite_priority_display_list.sv
sim/sprite_priority_display_list_tb.sv
